// ===== rtl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants for the tick task scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int TASK_SLOTS  = 16;
    localparam int SEM_COUNT   = 32;
    localparam int QUEUE_COUNT = 8;
    localparam int TIMER_BITS  = 16;
    localparam int TASK_W      = $clog2(TASK_SLOTS);
    localparam int SLOT_CNT_W  = $clog2(TASK_SLOTS + 1);
    localparam int SEM_W       = $clog2(SEM_COUNT);
    localparam int QUEUE_SEMS  = 2 * QUEUE_COUNT;
    localparam int CMDQ_DEPTH  = 2;

    typedef enum logic [2:0] {
        REQ_TICK      = 3'd0,
        REQ_START     = 3'd1,
        REQ_WAIT_SEM  = 3'd2,
        REQ_WAIT_TIME = 3'd3,
        REQ_SIGNAL    = 3'd4,
        REQ_PRESET    = 3'd5,
        REQ_SET_STATE = 3'd6,
        REQ_NONE      = 3'd7
    } req_t;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_SIGNAL  = 2'd1;
    localparam logic [1:0] EV_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  task_id;
        logic [4:0]  sem_index;
        logic [15:0] amount;
        logic [7:0]  user_state;
    } req_item_t;

    typedef struct packed {
        logic       run_valid;
        logic [3:0] run_task;
        logic [7:0] run_state;
        logic [1:0] run_event;
        logic       granted;
        logic [3:0] new_task;
        logic       table_full;
        logic       last;
    } rsp_item_t;

    typedef struct packed {
        logic                  started;
        logic                  wsem;
        logic                  wtime;
    } cond_t;

    typedef struct packed {
        req_t                  req;
        logic [TASK_W-1:0]     tid;
        logic                  task_ok;
        logic                  sem_ok;
        logic [SEM_W-1:0]      sem;
        logic [15:0]           amount;
        logic [7:0]            user_state;
    } cmd_t;

endpackage

// ===== rtl/tts_front.sv =====
// ----------------------------------------------------------------------------
// tts_front
// Accepts requests, classifies them and queues decoded commands.
// ----------------------------------------------------------------------------
module tts_front
    import tts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  req_item_t             req,
    input  logic                  accept,
    input  logic [SLOT_CNT_W-1:0] free_slot,
    output logic                  cmd_valid,
    output cmd_t                  cmd,
    input  logic                  cmd_pop
);

    cmd_t                  q_mem [CMDQ_DEPTH];
    logic                  wr_ptr_reg, rd_ptr_reg;
    logic [1:0]            cnt_reg;
    cmd_t                  dec;
    logic [SLOT_CNT_W-1:0] tid_ext;

    always_comb
    begin
        tid_ext        = SLOT_CNT_W'(req.task_id);
        dec.req        = req_t'(req.req_type);
        dec.tid        = TASK_W'(req.task_id);
        dec.task_ok    = (tid_ext < free_slot) && (32'(req.task_id) < TASK_SLOTS);
        dec.sem_ok     = 32'(req.sem_index) < SEM_COUNT;
        dec.sem        = SEM_W'(req.sem_index);
        dec.amount     = req.amount;
        dec.user_state = req.user_state;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(accept) - 2'(cmd_pop);
        end
    end

    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd       = q_mem[rd_ptr_reg];

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> cnt_reg != 2'd2) else $error("command queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid) else $error("command queue underflow");
    a_start_only: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> start) else $error("accept without start");
`endif

endmodule

// ===== rtl/tts_back.sv =====
// ----------------------------------------------------------------------------
// tts_back
// Executes commands against the task table and semaphores; walks ticks.
// ----------------------------------------------------------------------------
module tts_back
    import tts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  cmd_pop,
    output logic [SLOT_CNT_W-1:0] free_slot,
    output logic                  idle,
    output logic                  result_strobe,
    output rsp_item_t             result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMPTY
    } state_t;

    state_t                  state_reg;
    cond_t                   cond_reg  [TASK_SLOTS];
    logic [SEM_W-1:0]        wsem_reg  [TASK_SLOTS];
    logic [TIMER_BITS-1:0]   timer_reg [TASK_SLOTS];
    logic [7:0]              ustate_reg[TASK_SLOTS];
    logic [1:0]              event_reg [TASK_SLOTS];
    logic [7:0]              sem_reg   [SEM_COUNT];
    logic [SLOT_CNT_W-1:0]   free_reg;
    logic [TASK_W-1:0]       idx_reg;
    logic                    any_reg;
    logic                    pend_reg;
    rsp_item_t               pend_item_reg;
    logic                    strobe_reg;
    rsp_item_t               result_reg;

    cond_t                   c_cur;
    logic [SEM_W-1:0]        s_cur;
    logic [7:0]              s_cnt;
    logic                    sem_wake;
    logic                    c_after_sem_wsem;
    logic                    c_after_sem_wtime;
    logic [TIMER_BITS-1:0]   t_dec;
    logic                    time_run;
    logic                    time_wake;
    logic                    ready_now;
    logic [1:0]              ev_now;
    logic                    last_slot;
    logic [7:0]              cmd_sem_cnt;
    logic [TIMER_BITS-1:0]   amt_t;
    rsp_item_t               cmd_rsp;
    rsp_item_t               walk_rsp;
    rsp_item_t               close_rsp;

    always_comb
    begin
        c_cur             = cond_reg[idx_reg];
        s_cur             = wsem_reg[idx_reg];
        s_cnt             = sem_reg[s_cur];
        sem_wake          = c_cur.wsem && (s_cnt != 8'd0);
        c_after_sem_wsem  = c_cur.wsem && !sem_wake;
        c_after_sem_wtime = c_cur.wtime && !sem_wake;
        t_dec             = timer_reg[idx_reg] - TIMER_BITS'(1);
        time_run          = c_after_sem_wtime && (timer_reg[idx_reg] != '0);
        time_wake         = time_run && (t_dec == '0);
        ready_now         = c_cur.started &&
                            ((!c_after_sem_wsem && !c_after_sem_wtime) || time_wake);
        ev_now            = time_wake ? EV_TIMEOUT :
                            (sem_wake ? EV_SIGNAL : event_reg[idx_reg]);
        last_slot         = (SLOT_CNT_W'(idx_reg) + SLOT_CNT_W'(1)) >= free_reg;
        cmd_sem_cnt       = sem_reg[cmd.sem];
        amt_t             = TIMER_BITS'(cmd.amount);

        cmd_rsp      = '0;
        cmd_rsp.last = 1'b1;
        unique case (cmd.req)
            REQ_START:
            begin
                if (32'(free_reg) < TASK_SLOTS)
                begin
                    cmd_rsp.new_task = 4'(free_reg);
                end
                else
                begin
                    cmd_rsp.table_full = 1'b1;
                end
            end
            REQ_WAIT_SEM:
            begin
                cmd_rsp.granted = cmd.task_ok && cmd.sem_ok && (cmd_sem_cnt != 8'd0);
            end
            default:
            begin
            end
        endcase

        walk_rsp           = '0;
        walk_rsp.run_valid = 1'b1;
        walk_rsp.run_task  = 4'(idx_reg);
        walk_rsp.run_state = ustate_reg[idx_reg];
        walk_rsp.run_event = ev_now;

        if (pend_reg)
        begin
            close_rsp = pend_item_reg;
        end
        else
        begin
            close_rsp = '0;
        end
        close_rsp.last = 1'b1;
    end

    assign cmd_pop = cmd_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            unique case (cmd.req)
                REQ_START:
                begin
                    if (32'(free_reg) < TASK_SLOTS)
                    begin
                        ustate_reg[TASK_W'(free_reg)] <= 8'd0;
                        timer_reg[TASK_W'(free_reg)]  <= '0;
                    end
                end
                REQ_WAIT_SEM:
                begin
                    if (cmd.task_ok && !(cmd.sem_ok && cmd_sem_cnt != 8'd0))
                    begin
                        wsem_reg[cmd.tid] <= cmd.sem;
                        if (cmd.amount != 16'd0)
                        begin
                            timer_reg[cmd.tid] <= amt_t;
                        end
                    end
                end
                REQ_WAIT_TIME:
                begin
                    if (cmd.task_ok)
                    begin
                        timer_reg[cmd.tid] <= amt_t;
                    end
                end
                REQ_SET_STATE:
                begin
                    if (cmd.task_ok)
                    begin
                        ustate_reg[cmd.tid] <= cmd.user_state;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == ST_WALK)
        begin
            if (time_run)
            begin
                timer_reg[idx_reg] <= t_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_reg      <= '0;
            idx_reg       <= '0;
            any_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            pend_item_reg <= '0;
            strobe_reg    <= 1'b0;
            result_reg    <= '0;
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                cond_reg[i]  <= '0;
                event_reg[i] <= EV_NONE;
            end
            for (int i = 0; i < SEM_COUNT; i++)
            begin
                sem_reg[i] <= 8'd0;
            end
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        result_reg <= cmd_rsp;
                        unique case (cmd.req)
                            REQ_TICK:
                            begin
                                idx_reg  <= '0;
                                any_reg  <= 1'b0;
                                pend_reg <= 1'b0;
                                state_reg <= (free_reg == '0) ? ST_EMPTY : ST_WALK;
                            end
                            REQ_START:
                            begin
                                strobe_reg <= 1'b1;
                                if (32'(free_reg) < TASK_SLOTS)
                                begin
                                    cond_reg[TASK_W'(free_reg)] <= '{1'b1, 1'b0, 1'b0};
                                    free_reg <= free_reg + SLOT_CNT_W'(1);
                                end
                            end
                            REQ_WAIT_SEM:
                            begin
                                strobe_reg <= 1'b1;
                                if (cmd.task_ok)
                                begin
                                    if (cmd.sem_ok && cmd_sem_cnt != 8'd0)
                                    begin
                                        sem_reg[cmd.sem] <= cmd_sem_cnt - 8'd1;
                                        cond_reg[cmd.tid] <= '{1'b1, 1'b0, 1'b0};
                                    end
                                    else
                                    begin
                                        cond_reg[cmd.tid] <=
                                            '{1'b1, 1'b1, cmd.amount != 16'd0};
                                    end
                                end
                            end
                            REQ_WAIT_TIME:
                            begin
                                strobe_reg <= 1'b1;
                                if (cmd.task_ok)
                                begin
                                    cond_reg[cmd.tid] <= '{1'b1, 1'b0, 1'b1};
                                end
                            end
                            REQ_SIGNAL:
                            begin
                                strobe_reg <= 1'b1;
                                if (cmd.sem_ok && cmd_sem_cnt != 8'hFF)
                                begin
                                    sem_reg[cmd.sem] <= cmd_sem_cnt + 8'd1;
                                end
                            end
                            REQ_PRESET:
                            begin
                                strobe_reg <= 1'b1;
                                if (cmd.sem_ok)
                                begin
                                    sem_reg[cmd.sem] <= cmd.amount[7:0];
                                end
                            end
                            default:
                            begin
                                strobe_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_WALK:
                begin
                    if (sem_wake && !(32'(s_cur) < QUEUE_SEMS))
                    begin
                        sem_reg[s_cur] <= s_cnt - 8'd1;
                    end
                    if (sem_wake || time_wake)
                    begin
                        cond_reg[idx_reg]  <= '{1'b1, 1'b0, 1'b0};
                        event_reg[idx_reg] <= ev_now;
                    end
                    if (ready_now)
                    begin
                        if (pend_reg)
                        begin
                            strobe_reg <= 1'b1;
                            result_reg <= pend_item_reg;
                        end
                        pend_reg      <= 1'b1;
                        any_reg       <= 1'b1;
                        pend_item_reg <= walk_rsp;
                    end
                    if (last_slot)
                    begin
                        state_reg <= ST_EMPTY;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + TASK_W'(1);
                    end
                end
                ST_EMPTY:
                begin
                    strobe_reg <= 1'b1;
                    result_reg <= close_rsp;
                    pend_reg   <= 1'b0;
                    state_reg  <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign free_slot     = free_reg;
    assign idle          = (state_reg == ST_IDLE) && !cmd_valid;
    assign result_strobe = strobe_reg;
    assign result        = result_reg;

`ifndef NO_ASSERTIONS
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(free_reg) <= TASK_SLOTS) else $error("slot count out of range");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> SLOT_CNT_W'(idx_reg) < free_reg)
        else $error("walk past last started slot");
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMPTY |=> strobe_reg && result_reg.last)
        else $error("tick did not close with last");
    a_any_seen: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> any_reg) else $error("pending result without ready task");
`endif

endmodule

// ===== rtl/tick_task_scheduler_with_semaphores.sv =====
// ----------------------------------------------------------------------------
// tick_task_scheduler_with_semaphores
// Run-to-completion task scheduler with counting semaphores.
// ----------------------------------------------------------------------------
// A request transfers when start is high and busy is low; busy stays high until
// every result of that request has been shown. A non-tick request gives one
// result, registered by the back end after it pops the command from the queue;
// the next transfer can come once busy falls. A tick walks the started slots in
// index order, one slot per cycle through the back-end sequencer, and closes
// with a final result. A ready task is shown once the walk reaches the next
// ready task or the end; the final one, or a single empty result, is flagged
// last. Results are strobed by done for exactly one cycle and cannot be held
// off.
module tick_task_scheduler_with_semaphores
    import tts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  req_item_t req,
    output logic      done,
    output rsp_item_t rsp
);

    logic                  accept;
    logic                  cmd_valid;
    logic                  cmd_pop;
    cmd_t                  cmd;
    logic [SLOT_CNT_W-1:0] free_slot;
    logic                  back_idle;
    logic                  busy_reg;

    assign accept = start && !busy;
    assign busy   = busy_reg || !back_idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
        end
        else if (done && rsp.last)
        begin
            busy_reg <= 1'b0;
        end
    end

    tts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .accept    (accept),
        .free_slot (free_slot),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tts_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .free_slot     (free_slot),
        .idle          (back_idle),
        .result_strobe (done),
        .result        (rsp)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy) else $error("busy not raised after transfer");
    a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg) else $error("result without open request");
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.last |=> !busy_reg) else $error("busy held after last");
`endif

endmodule

// ===== sim/tts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_checker
// Watches request and result transfers of the scheduler, predicts every
// result from its own copy of the task table and semaphores, and compares.
// ----------------------------------------------------------------------------
module tts_checker
    import tts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  req_item_t req,
    input  logic      done,
    input  rsp_item_t rsp,
    output int        fail_count,
    output int        pending,
    output int        result_count
);

    logic [2:0]  cond_q  [TASK_SLOTS];
    logic [4:0]  wsem_q  [TASK_SLOTS];
    logic [15:0] timer_q [TASK_SLOTS];
    logic [7:0]  ustate_q[TASK_SLOTS];
    logic [1:0]  event_q [TASK_SLOTS];
    logic [7:0]  sem_q   [SEM_COUNT];
    int          free_slot;
    rsp_item_t   expected_rsp[$];

    localparam logic [2:0] C_STARTED = 3'b001;
    localparam logic [2:0] C_WSEM    = 3'b010;
    localparam logic [2:0] C_WTIME   = 3'b100;

    assign pending = expected_rsp.size();

    function automatic rsp_item_t blank_rsp();
        rsp_item_t r;
        r = '0;
        return r;
    endfunction

    task automatic schedule_request(input req_item_t q);
        rsp_item_t r;
        int        n;
        int        s;
        bit        ok;
        r  = blank_rsp();
        ok = (q.task_id < free_slot);
        case (req_t'(q.req_type))
            REQ_TICK:
            begin
                n = 0;
                for (int t = 0; t < free_slot; t++)
                begin
                    if (cond_q[t] & C_WSEM)
                    begin
                        s = wsem_q[t];
                        if (sem_q[s] != 0)
                        begin
                            if (s >= QUEUE_SEMS)
                                sem_q[s]--;
                            event_q[t] = EV_SIGNAL;
                            cond_q[t]  = C_STARTED;
                        end
                    end
                    if ((cond_q[t] & C_WTIME) && timer_q[t] != 0)
                    begin
                        timer_q[t]--;
                        if (timer_q[t] == 0)
                        begin
                            event_q[t] = EV_TIMEOUT;
                            cond_q[t]  = C_STARTED;
                        end
                    end
                    if (cond_q[t] == C_STARTED && n < 16)
                    begin
                        r = blank_rsp();
                        r.run_valid = 1'b1;
                        r.run_task  = t[3:0];
                        r.run_state = ustate_q[t];
                        r.run_event = event_q[t];
                        expected_rsp.push_back(r);
                        n++;
                    end
                end
                if (n == 0)
                begin
                    r.last = 1'b1;
                    expected_rsp.push_back(r);
                end
                else
                    expected_rsp[$].last = 1'b1;
                return;
            end
            REQ_START:
                if (free_slot < TASK_SLOTS)
                begin
                    cond_q[free_slot]   = C_STARTED;
                    ustate_q[free_slot] = '0;
                    timer_q[free_slot]  = '0;
                    r.new_task = free_slot[3:0];
                    free_slot++;
                end
                else
                    r.table_full = 1'b1;
            REQ_WAIT_SEM:
                if (ok)
                begin
                    if (sem_q[q.sem_index] != 0)
                    begin
                        sem_q[q.sem_index]--;
                        cond_q[q.task_id] = C_STARTED;
                        r.granted = 1'b1;
                    end
                    else
                    begin
                        wsem_q[q.task_id] = q.sem_index;
                        cond_q[q.task_id] = C_STARTED | C_WSEM;
                        if (q.amount != 0)
                        begin
                            timer_q[q.task_id] = q.amount;
                            cond_q[q.task_id]  = C_STARTED | C_WSEM | C_WTIME;
                        end
                    end
                end
            REQ_WAIT_TIME:
                if (ok)
                begin
                    timer_q[q.task_id] = q.amount;
                    cond_q[q.task_id]  = C_STARTED | C_WTIME;
                end
            REQ_SIGNAL:
                if (sem_q[q.sem_index] != 8'hff)
                    sem_q[q.sem_index]++;
            REQ_PRESET:
                sem_q[q.sem_index] = q.amount[7:0];
            REQ_SET_STATE:
                if (ok)
                    ustate_q[q.task_id] = q.user_state;
            default:
                ;
        endcase
        r.last = 1'b1;
        expected_rsp.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                cond_q[i] = '0; wsem_q[i] = '0; timer_q[i] = '0;
                ustate_q[i] = '0; event_q[i] = '0;
            end
            for (int i = 0; i < SEM_COUNT; i++)
                sem_q[i] = '0;
            free_slot = 0;
            fail_count = 0;
            result_count = 0;
            expected_rsp.delete();
        end
        else
        begin
            if (done)
            begin
                result_count++;
                if (expected_rsp.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h", rsp);
                end
                else
                begin
                    if (rsp !== expected_rsp[0])
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p",
                                     expected_rsp[0], rsp);
                    end
                    void'(expected_rsp.pop_front());
                end
            end
            if (start && !busy)
                schedule_request(req);
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random scheduler requests, most random ones with random
// gaps, and checks every result through the checker.
// ----------------------------------------------------------------------------
module tb_top;
    import tts_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    req_item_t req;
    logic      done;
    rsp_item_t rsp;
    int        fail_count;
    int        pending;
    int        result_count;
    int        cycles;
    int        sent;

    tick_task_scheduler_with_semaphores dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .done(done), .rsp(rsp)
    );

    tts_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending),
        .result_count(result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("** tick_task_scheduler_with_semaphores: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_req(input logic [2:0] rt, input logic [3:0] tid,
                            input logic [4:0] sem, input logic [15:0] amt,
                            input logic [7:0] st, input bit gaps);
        int gap;
        @(posedge clk);
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= '{rt, tid, sem, amt, st};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        start <= 1'b0;
    endtask

    task automatic random_req(input bit gaps);
        int          pick;
        logic [2:0]  rt;
        logic [15:0] amt;
        pick = $urandom_range(0, 99);
        if (pick < 30)      rt = REQ_TICK;
        else if (pick < 36) rt = REQ_START;
        else if (pick < 54) rt = REQ_WAIT_SEM;
        else if (pick < 64) rt = REQ_WAIT_TIME;
        else if (pick < 80) rt = REQ_SIGNAL;
        else if (pick < 86) rt = REQ_PRESET;
        else if (pick < 96) rt = REQ_SET_STATE;
        else                rt = 3'($urandom_range(0, 7));
        amt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
        send_req(rt, 4'($urandom), 5'($urandom), amt, 8'($urandom), gaps);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        sent  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(REQ_TICK, 4'd0, 5'd0, 16'd0, 8'd0, 1'b0);
        send_req(REQ_WAIT_TIME, 4'd0, 5'd0, 16'd5, 8'd0, 1'b0);
        send_req(REQ_START, 4'd0, 5'd0, 16'd0, 8'd0, 1'b0);
        send_req(REQ_START, 4'd0, 5'd0, 16'd0, 8'd0, 1'b0);
        send_req(REQ_SET_STATE, 4'd1, 5'd0, 16'd0, 8'hff, 1'b0);
        send_req(REQ_PRESET, 4'd0, 5'd31, 16'hffff, 8'd0, 1'b0);
        send_req(REQ_SIGNAL, 4'd0, 5'd31, 16'd0, 8'd0, 1'b0);
        send_req(REQ_WAIT_SEM, 4'd0, 5'd31, 16'd0, 8'd0, 1'b0);
        send_req(REQ_WAIT_SEM, 4'd1, 5'd3, 16'hffff, 8'd0, 1'b0);
        send_req(REQ_WAIT_TIME, 4'd0, 5'd0, 16'd2, 8'd0, 1'b0);
        send_req(REQ_TICK, 4'd0, 5'd0, 16'd0, 8'd0, 1'b0);
        send_req(REQ_SIGNAL, 4'd0, 5'd3, 16'd0, 8'd0, 1'b0);
        send_req(REQ_TICK, 4'd0, 5'd0, 16'd0, 8'd0, 1'b0);
        send_req(REQ_TICK, 4'd0, 5'd0, 16'd0, 8'd0, 1'b0);
        send_req(REQ_WAIT_TIME, 4'd0, 5'd0, 16'd0, 8'd0, 1'b0);
        send_req(REQ_NONE, 4'hf, 5'h1f, 16'hffff, 8'hff, 1'b0);
        repeat (16) send_req(REQ_START, 4'd0, 5'd0, 16'd0, 8'd0, 1'b0);
        send_req(REQ_TICK, 4'd0, 5'd0, 16'd0, 8'd0, 1'b0);

        while (pending != 0)
            @(posedge clk);

        repeat (120) random_req(1);
        while (pending != 0)
            @(posedge clk);
        repeat (90) random_req(1);
        repeat (40) random_req(0);

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("sent %0d requests, checked %0d results", sent, result_count);
        if (fail_count == 0 && pending == 0)
            $display("** tick_task_scheduler_with_semaphores: PASSED **");
        else
            $display("** tick_task_scheduler_with_semaphores: FAILED **");
        $finish;
    end

endmodule
